// ===== rtl/ray_sphere_pixel_shader_defines.svh =====
// Assertion shorthands used by the checker file.
`ifndef RAY_SPHERE_PIXEL_SHADER_DEFINES_SVH
`define RAY_SPHERE_PIXEL_SHADER_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ray sphere shader check failed");

// Condition that must never be seen outside reset.
`define RSS_ASSERT_NEVER(lbl, bad) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(bad)) \
    else $error("ray sphere shader check failed");

`endif

// ===== rtl/rss_pkg.sv =====
package rss_pkg;

  // Fixed-point scaling of the geometry
  localparam int UNIT_SHIFT = 14;
  localparam int PT_SHIFT   = 20;
  localparam int C_SHIFT    = 28;

  // Internal widths, sized for image dimensions up to 4096
  localparam int EW     = 28;  // magnitude of an eye direction component
  localparam int NSQ_W  = 58;  // squared length of the eye direction
  localparam int N_W    = NSQ_W / 2;
  localparam int UQ_W   = 15;  // magnitude of a unit direction component
  localparam int U_W    = 16;  // signed Q2.14 unit direction component
  localparam int DISC_W = 60;
  localparam int S_W    = DISC_W / 2;
  localparam int VEC_W  = 26;  // normal and light vector components
  localparam int LEN_W  = 52;  // squared vector lengths
  localparam int DOT_W  = 54;
  localparam int NUM_W  = 55;
  localparam int SH_W   = 63;  // base color times numerator
  localparam int SQ_W   = 10;  // shading quotient, below 1024

  localparam logic [7:0] BASE_RED   = 8'd118;
  localparam logic [7:0] BASE_GREEN = 8'd0;
  localparam logic [7:0] BASE_BLUE  = 8'd185;

  typedef enum logic [2:0] {
    REG_SPHERE_X = 3'd0,
    REG_SPHERE_Y = 3'd1,
    REG_SPHERE_Z = 3'd2,
    REG_SPHERE_R = 3'd3,
    REG_LIGHT_X  = 3'd4,
    REG_LIGHT_Y  = 3'd5,
    REG_LIGHT_Z  = 3'd6
  } cfg_reg_t;

endpackage

// ===== rtl/rss_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, several lanes.
module rss_isqrt #(
  parameter int IN_W  = 58,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [IN_W-1:0]       in_rad [LANES],
  input  logic [PW-1:0]         in_pay,
  output logic                  out_valid,
  output logic [IN_W/2-1:0]     out_root [LANES],
  output logic [PW-1:0]         out_pay
);

  localparam int OW = IN_W / 2;
  localparam int RW = OW + 2;

  logic [IN_W-1:0] rad_r  [OW][LANES];
  logic [RW-1:0]   rem_r  [OW][LANES];
  logic [OW-1:0]   root_r [OW][LANES];
  logic [OW-1:0]   vld_r;
  logic [PW-1:0]   pay_r  [OW];

  for (genvar s = 0; s < OW; s++) begin : g_stage
    logic [IN_W-1:0] rad_p  [LANES];
    logic [RW-1:0]   rem_p  [LANES];
    logic [OW-1:0]   root_p [LANES];
    logic            vld_p;
    logic [PW-1:0]   pay_p;
    logic [RW-1:0]   cand_c  [LANES];
    logic [RW-1:0]   trial_c [LANES];

    if (s == 0) begin : g_head
      assign rad_p  = in_rad;
      assign rem_p  = '{default: '0};
      assign root_p = '{default: '0};
      assign vld_p  = in_valid;
      assign pay_p  = in_pay;
    end else begin : g_body
      assign rad_p  = rad_r[s-1];
      assign rem_p  = rem_r[s-1];
      assign root_p = root_r[s-1];
      assign vld_p  = vld_r[s-1];
      assign pay_p  = pay_r[s-1];
    end

    // Bring down the next two radicand bits and form the trial divisor
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        cand_c[l]  = {rem_p[l][RW-3:0], rad_p[l][IN_W-1 -: 2]};
        trial_c[l] = {root_p[l], 2'b01};
      end
    end

    // Advance one root bit
    always_ff @(posedge clk) begin
      for (int l = 0; l < LANES; l++) begin
        rad_r[s][l] <= rad_p[l] << 2;
        if (cand_c[l] >= trial_c[l]) begin
          rem_r[s][l]  <= cand_c[l] - trial_c[l];
          root_r[s][l] <= {root_p[l][OW-2:0], 1'b1};
        end else begin
          rem_r[s][l]  <= cand_c[l];
          root_r[s][l] <= {root_p[l][OW-2:0], 1'b0};
        end
      end
      pay_r[s] <= pay_p;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_p;
      end
    end
  end

  assign out_valid = vld_r[OW-1];
  assign out_root  = root_r[OW-1];
  assign out_pay   = pay_r[OW-1];

endmodule

// ===== rtl/rss_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, lanes share the divisor.
// The quotient must fit in Q_W bits.
module rss_div #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 29,
  parameter int Q_W   = 15,
  parameter int LANES = 1,
  parameter int PW    = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [NUM_W-1:0]   in_num [LANES],
  input  logic [DEN_W-1:0]   in_den,
  input  logic [PW-1:0]      in_pay,
  output logic               out_valid,
  output logic [Q_W-1:0]     out_quo [LANES],
  output logic [PW-1:0]      out_pay
);

  localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [NUM_W-1:0] rem_r [Q_W][LANES];
  logic [Q_W-1:0]   quo_r [Q_W][LANES];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   vld_r;
  logic [PW-1:0]    pay_r [Q_W];

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    localparam int K = Q_W - 1 - s;
    logic [NUM_W-1:0] rem_p [LANES];
    logic [Q_W-1:0]   quo_p [LANES];
    logic [DEN_W-1:0] den_p;
    logic             vld_p;
    logic [PW-1:0]    pay_p;
    logic [CW-1:0]    dsh_c;
    logic [LANES-1:0] ge_c;

    if (s == 0) begin : g_head
      assign rem_p = in_num;
      assign quo_p = '{default: '0};
      assign den_p = in_den;
      assign vld_p = in_valid;
      assign pay_p = in_pay;
    end else begin : g_body
      assign rem_p = rem_r[s-1];
      assign quo_p = quo_r[s-1];
      assign den_p = den_r[s-1];
      assign vld_p = vld_r[s-1];
      assign pay_p = pay_r[s-1];
    end

    // Compare against the divisor at this quotient weight
    always_comb begin
      dsh_c = CW'(den_p) << K;
      for (int l = 0; l < LANES; l++) begin
        ge_c[l] = CW'(rem_p[l]) >= dsh_c;
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < LANES; l++) begin
        rem_r[s][l] <= ge_c[l] ? NUM_W'(CW'(rem_p[l]) - dsh_c) : rem_p[l];
        quo_r[s][l] <= {quo_p[l][Q_W-2:0], ge_c[l]};
      end
      den_r[s] <= den_p;
      pay_r[s] <= pay_p;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_p;
      end
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_quo   = quo_r[Q_W-1];
  assign out_pay   = pay_r[Q_W-1];

endmodule

// ===== rtl/ray_sphere_pixel_shader.sv =====
// Ray/sphere pixel shader. Pulse start with a pixel column and row to shade one pixel; busy
// never rises, so a new pixel can go in on every clock. The result appears on out_red,
// out_green, out_blue and out_hit with a one-cycle out_valid strobe, in the order the pixels
// went in; it cannot be held off, so capture it on the strobe. The pipeline is made of the three
// square-root pipelines (29, 30 and 26 stages, the last one taking both vector lengths side by
// side) and the two dividers (15 and 10 stages), one result bit per stage, plus 16 stages of
// multiply and add. Registers are written through the cfg port, which is always ready; write
// them only while no pixel is in flight.
module ray_sphere_pixel_shader #(
  parameter int IMAGE_WIDTH  = 256,
  parameter int IMAGE_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_pixel_col,
  input  logic [7:0]  in_pixel_row,
  output logic        out_valid,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_hit,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int EW     = rss_pkg::EW;
  localparam int N_W    = rss_pkg::N_W;
  localparam int UQ_W   = rss_pkg::UQ_W;
  localparam int U_W    = rss_pkg::U_W;
  localparam int S_W    = rss_pkg::S_W;
  localparam int VEC_W  = rss_pkg::VEC_W;
  localparam int LEN_W  = rss_pkg::LEN_W;
  localparam int DOT_W  = rss_pkg::DOT_W;
  localparam int NUM_W  = rss_pkg::NUM_W;
  localparam int SH_W   = rss_pkg::SH_W;
  localparam int SQ_W   = rss_pkg::SQ_W;
  localparam int NSQ_W  = rss_pkg::NSQ_W;
  localparam int DISC_W = rss_pkg::DISC_W;

  localparam int     EX_SCALE = 10 * IMAGE_HEIGHT;
  localparam int     EY_SCALE = 10 * IMAGE_WIDTH;
  localparam longint EZ       = 14 * longint'(IMAGE_WIDTH) * longint'(IMAGE_HEIGHT);
  localparam longint EZ_SQ    = EZ * EZ;
  localparam int     PW_N     = 2 + 2 * EW;
  localparam int     PW_S     = 1 + S_W + 3 * U_W;
  localparam int     PW_L     = 1 + DOT_W;

  // ---------------------------------------------------------------- configuration
  logic signed [15:0] sphere_x_r, sphere_y_r, sphere_z_r;
  logic        [14:0] sphere_r_r;
  logic signed [15:0] light_x_r, light_y_r, light_z_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sphere_x_r <= 16'sd0;
      sphere_y_r <= 16'sd0;
      sphere_z_r <= 16'sd2560;
      sphere_r_r <= 15'd1024;
      light_x_r  <= 16'sd0;
      light_y_r  <= 16'sd2560;
      light_z_r  <= 16'sd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rss_pkg::cfg_reg_t'(cfg_index))
        rss_pkg::REG_SPHERE_X: sphere_x_r <= cfg_data;
        rss_pkg::REG_SPHERE_Y: sphere_y_r <= cfg_data;
        rss_pkg::REG_SPHERE_Z: sphere_z_r <= cfg_data;
        rss_pkg::REG_SPHERE_R: sphere_r_r <= cfg_data[14:0];
        rss_pkg::REG_LIGHT_X:  light_x_r  <= cfg_data;
        rss_pkg::REG_LIGHT_Y:  light_y_r  <= cfg_data;
        rss_pkg::REG_LIGHT_Z:  light_z_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [15:0] ctr_c [3];
  logic signed [15:0] lgt_c [3];
  assign ctr_c = '{sphere_x_r, sphere_y_r, sphere_z_r};
  assign lgt_c = '{light_x_r, light_y_r, light_z_r};

  // ---------------------------------------------------------------- eye direction
  logic               in_acc;
  logic signed [13:0] ax_c, ay_c;
  logic signed [28:0] ex_c, ey_c;

  assign in_acc = start & ~busy;
  assign ax_c   = 14'(IMAGE_WIDTH - 1) - 14'({in_pixel_col, 1'b0});
  assign ay_c   = 14'(IMAGE_HEIGHT - 1) - 14'({in_pixel_row, 1'b0});
  assign ex_c   = 29'(ax_c) * 29'(EX_SCALE);
  assign ey_c   = 29'(ay_c) * 29'(EY_SCALE);

  logic              v0_r, v1_r, v2_r;
  logic [PW_N-1:0]   pay0_r, pay1_r, pay2_r;
  logic [2*EW-1:0]   exsq1_r, eysq1_r;
  logic [NSQ_W-1:0]  nsq2_r;

  // Take magnitudes, square them, add the constant depth term
  always_ff @(posedge clk) begin
    pay0_r  <= {ex_c[28], ey_c[28],
                ex_c[28] ? EW'(-ex_c) : EW'(ex_c),
                ey_c[28] ? EW'(-ey_c) : EW'(ey_c)};
    exsq1_r <= (2*EW)'(pay0_r[2*EW-1:EW]) * (2*EW)'(pay0_r[2*EW-1:EW]);
    eysq1_r <= (2*EW)'(pay0_r[EW-1:0]) * (2*EW)'(pay0_r[EW-1:0]);
    pay1_r  <= pay0_r;
    nsq2_r  <= NSQ_W'(exsq1_r) + NSQ_W'(eysq1_r) + NSQ_W'(EZ_SQ);
    pay2_r  <= pay1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= in_acc;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  // Length of the eye direction
  logic [NSQ_W-1:0] nsq_arr [1];
  logic [N_W-1:0]   n_arr   [1];
  logic             vn_c;
  logic [PW_N-1:0]  payn_c;

  assign nsq_arr[0] = nsq2_r;

  rss_isqrt #(.IN_W(NSQ_W), .LANES(1), .PW(PW_N)) u_sqrt_len (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v2_r),
    .in_rad    (nsq_arr),
    .in_pay    (pay2_r),
    .out_valid (vn_c),
    .out_root  (n_arr),
    .out_pay   (payn_c)
  );

  // Normalize: |e| * 2^14 / n per component
  logic [EW+rss_pkg::UNIT_SHIFT-1:0] unum_c [3];
  logic [UQ_W-1:0]                   uq_c   [3];
  logic                              vu_c;
  logic [1:0]                        uneg_c;

  assign unum_c[0] = {payn_c[2*EW-1:EW], {rss_pkg::UNIT_SHIFT{1'b0}}};
  assign unum_c[1] = {payn_c[EW-1:0], {rss_pkg::UNIT_SHIFT{1'b0}}};
  assign unum_c[2] = (EW+rss_pkg::UNIT_SHIFT)'(EZ << rss_pkg::UNIT_SHIFT);

  rss_div #(.NUM_W(EW+rss_pkg::UNIT_SHIFT), .DEN_W(N_W), .Q_W(UQ_W), .LANES(3), .PW(2))
  u_div_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vn_c),
    .in_num    (unum_c),
    .in_den    (n_arr[0]),
    .in_pay    (payn_c[PW_N-1 -: 2]),
    .out_valid (vu_c),
    .out_quo   (uq_c),
    .out_pay   (uneg_c)
  );

  // ---------------------------------------------------------------- ray vs sphere
  logic signed [U_W-1:0] u_c [3];

  always_comb begin
    u_c[0] = uneg_c[1] ? -U_W'(uq_c[0]) : U_W'(uq_c[0]);
    u_c[1] = uneg_c[0] ? -U_W'(uq_c[1]) : U_W'(uq_c[1]);
    u_c[2] = U_W'(uq_c[2]);
  end

  logic                  g1_v_r, g2_v_r, g3_v_r, g4_v_r;
  logic signed [U_W-1:0] u1_r [3];
  logic signed [U_W-1:0] u2_r [3];
  logic signed [U_W-1:0] u3_r [3];
  logic signed [U_W-1:0] u4_r [3];
  logic signed [31:0]    hp1_r [3];
  logic        [30:0]    csq1_r [3];
  logic        [29:0]    rsq1_r;
  logic signed [33:0]    h2_r, c2_r;
  logic        [DISC_W-1:0] hsq3_r;
  logic        [31:0]    c3_r;
  logic        [S_W-1:0] h3_r, h4_r;
  logic                  miss3_r, miss4_r;
  logic        [DISC_W-1:0] disc4_r;
  logic        [DISC_W-1:0] csh_c;
  logic                  miss3_c;

  assign miss3_c = (c2_r <= 34'sd0) || (h2_r <= 34'sd0);
  assign csh_c   = {c3_r, {rss_pkg::C_SHIFT{1'b0}}};

  // Projections, squared distance, discriminant
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u1_r[i]   <= u_c[i];
      hp1_r[i]  <= 32'(u_c[i]) * 32'(ctr_c[i]);
      csq1_r[i] <= 31'(32'(ctr_c[i]) * 32'(ctr_c[i]));
      u2_r[i]   <= u1_r[i];
      u3_r[i]   <= u2_r[i];
      u4_r[i]   <= u3_r[i];
    end
    rsq1_r  <= 30'(sphere_r_r) * 30'(sphere_r_r);
    h2_r    <= 34'(hp1_r[0]) + 34'(hp1_r[1]) + 34'(hp1_r[2]);
    c2_r    <= 34'(csq1_r[0]) + 34'(csq1_r[1]) + 34'(csq1_r[2]) - 34'(rsq1_r);
    hsq3_r  <= DISC_W'(h2_r[S_W-1:0]) * DISC_W'(h2_r[S_W-1:0]);
    c3_r    <= c2_r[31:0];
    h3_r    <= h2_r[S_W-1:0];
    miss3_r <= miss3_c;
    disc4_r <= hsq3_r - csh_c;
    miss4_r <= miss3_r || (hsq3_r < csh_c);
    h4_r    <= h3_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_v_r <= 1'b0;
      g2_v_r <= 1'b0;
      g3_v_r <= 1'b0;
      g4_v_r <= 1'b0;
    end else begin
      g1_v_r <= vu_c;
      g2_v_r <= g1_v_r;
      g3_v_r <= g2_v_r;
      g4_v_r <= g3_v_r;
    end
  end

  // Square root of the discriminant
  logic [DISC_W-1:0] disc_arr [1];
  logic [S_W-1:0]    s_arr    [1];
  logic              vs_c;
  logic [PW_S-1:0]   pays_c;

  assign disc_arr[0] = disc4_r;

  rss_isqrt #(.IN_W(DISC_W), .LANES(1), .PW(PW_S)) u_sqrt_disc (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (g4_v_r),
    .in_rad    (disc_arr),
    .in_pay    ({miss4_r, h4_r, u4_r[0], u4_r[1], u4_r[2]}),
    .out_valid (vs_c),
    .out_root  (s_arr),
    .out_pay   (pays_c)
  );

  // ---------------------------------------------------------------- hit point and vectors
  logic signed [U_W-1:0] us_c [3];
  assign us_c[0] = pays_c[3*U_W-1 -: U_W];
  assign us_c[1] = pays_c[2*U_W-1 -: U_W];
  assign us_c[2] = pays_c[U_W-1:0];

  localparam int PR_W = S_W + 1 + U_W;

  logic                    g5_v_r, g6_v_r, g7_v_r, g8_v_r, g9_v_r, g10_v_r;
  logic                    miss5_r, miss6_r, miss7_r, miss8_r, miss9_r, miss10_r;
  logic        [S_W-1:0]   t5_r;
  logic signed [U_W-1:0]   u5_r [3];
  logic signed [PR_W-1:0]  prod6_r [3];
  logic signed [PR_W-1:0]  pb_c [3];
  logic signed [24:0]      p7_r [3];
  logic signed [VEC_W-1:0] n8_r [3];
  logic signed [VEC_W-1:0] v8_r [3];
  logic signed [2*VEC_W-1:0] nv9_r [3];
  logic        [2*VEC_W-3:0] nsq9_r [3];
  logic        [2*VEC_W-3:0] vsq9_r [3];
  logic signed [DOT_W-1:0] dot10_r;
  logic        [LEN_W-1:0] nn10_r, vv10_r;

  // Round the scaled hit point toward zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pb_c[i] = prod6_r[i] + (prod6_r[i][PR_W-1] ?
                PR_W'((1 << rss_pkg::PT_SHIFT) - 1) : PR_W'(0));
    end
  end

  always_ff @(posedge clk) begin
    t5_r    <= pays_c[PW_S-2 -: S_W] - s_arr[0];
    miss5_r <= pays_c[PW_S-1];
    for (int i = 0; i < 3; i++) begin
      u5_r[i]    <= us_c[i];
      prod6_r[i] <= PR_W'($signed({1'b0, t5_r})) * PR_W'(u5_r[i]);
      p7_r[i]    <= 25'(pb_c[i] >>> rss_pkg::PT_SHIFT);
      n8_r[i]    <= VEC_W'(p7_r[i]) - VEC_W'($signed({ctr_c[i], 8'b0}));
      v8_r[i]    <= VEC_W'($signed({lgt_c[i], 8'b0})) - VEC_W'(p7_r[i]);
      nv9_r[i]   <= (2*VEC_W)'(n8_r[i]) * (2*VEC_W)'(v8_r[i]);
      nsq9_r[i]  <= (2*VEC_W-2)'((2*VEC_W)'(n8_r[i]) * (2*VEC_W)'(n8_r[i]));
      vsq9_r[i]  <= (2*VEC_W-2)'((2*VEC_W)'(v8_r[i]) * (2*VEC_W)'(v8_r[i]));
    end
    dot10_r  <= DOT_W'(nv9_r[0]) + DOT_W'(nv9_r[1]) + DOT_W'(nv9_r[2]);
    nn10_r   <= LEN_W'(nsq9_r[0]) + LEN_W'(nsq9_r[1]) + LEN_W'(nsq9_r[2]);
    vv10_r   <= LEN_W'(vsq9_r[0]) + LEN_W'(vsq9_r[1]) + LEN_W'(vsq9_r[2]);
    miss6_r  <= miss5_r;
    miss7_r  <= miss6_r;
    miss8_r  <= miss7_r;
    miss9_r  <= miss8_r;
    miss10_r <= miss9_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g5_v_r  <= 1'b0;
      g6_v_r  <= 1'b0;
      g7_v_r  <= 1'b0;
      g8_v_r  <= 1'b0;
      g9_v_r  <= 1'b0;
      g10_v_r <= 1'b0;
    end else begin
      g5_v_r  <= vs_c;
      g6_v_r  <= g5_v_r;
      g7_v_r  <= g6_v_r;
      g8_v_r  <= g7_v_r;
      g9_v_r  <= g8_v_r;
      g10_v_r <= g9_v_r;
    end
  end

  // Lengths of the normal and the light vector
  logic [LEN_W-1:0]   len_arr [2];
  logic [LEN_W/2-1:0] mag_arr [2];
  logic               vl_c;
  logic [PW_L-1:0]    payl_c;

  assign len_arr[0] = nn10_r;
  assign len_arr[1] = vv10_r;

  rss_isqrt #(.IN_W(LEN_W), .LANES(2), .PW(PW_L)) u_sqrt_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (g10_v_r),
    .in_rad    (len_arr),
    .in_pay    ({miss10_r, dot10_r}),
    .out_valid (vl_c),
    .out_root  (mag_arr),
    .out_pay   (payl_c)
  );

  // ---------------------------------------------------------------- shading
  logic                    g11_v_r, g12_v_r;
  logic                    miss11_r, miss12_r, dz12_r;
  logic        [LEN_W-1:0] den_c;
  logic        [LEN_W-1:0] den11_r, den12_r;
  logic signed [NUM_W-1:0] num11_r;
  logic                    npos_c;
  logic        [SH_W-1:0]  shn12_r [2];

  assign den_c  = LEN_W'(mag_arr[0]) * LEN_W'(mag_arr[1]);
  assign npos_c = !num11_r[NUM_W-1] && (num11_r != '0);

  always_ff @(posedge clk) begin
    den11_r    <= den_c;
    num11_r    <= $signed({(NUM_W-LEN_W)'(0), den_c}) + NUM_W'($signed(payl_c[DOT_W-1:0]));
    miss11_r   <= payl_c[PW_L-1];
    den12_r    <= den11_r;
    dz12_r     <= (den11_r == '0);
    miss12_r   <= miss11_r;
    shn12_r[0] <= npos_c ? SH_W'(num11_r) * SH_W'(rss_pkg::BASE_RED) : '0;
    shn12_r[1] <= npos_c ? SH_W'(num11_r) * SH_W'(rss_pkg::BASE_BLUE) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g11_v_r <= 1'b0;
      g12_v_r <= 1'b0;
    end else begin
      g11_v_r <= vl_c;
      g12_v_r <= g11_v_r;
    end
  end

  logic [SQ_W-1:0] sq_c [2];
  logic            vq_c;
  logic [1:0]      payq_c;

  rss_div #(.NUM_W(SH_W), .DEN_W(LEN_W), .Q_W(SQ_W), .LANES(2), .PW(2)) u_div_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (g12_v_r),
    .in_num    (shn12_r),
    .in_den    (den12_r),
    .in_pay    ({miss12_r, dz12_r}),
    .out_valid (vq_c),
    .out_quo   (sq_c),
    .out_pay   (payq_c)
  );

  // ---------------------------------------------------------------- result register
  logic       out_valid_r, out_hit_r;
  logic [7:0] out_red_r, out_green_r, out_blue_r;
  logic [7:0] red_c, blue_c;

  // Clamp the shaded value at white
  assign red_c  = (|sq_c[0][SQ_W-1:8]) ? 8'hFF : sq_c[0][7:0];
  assign blue_c = (|sq_c[1][SQ_W-1:8]) ? 8'hFF : sq_c[1][7:0];

  always_ff @(posedge clk) begin
    if (payq_c[1]) begin
      out_red_r   <= 8'd0;
      out_green_r <= 8'd0;
      out_blue_r  <= 8'd0;
    end else if (payq_c[0]) begin
      out_red_r   <= rss_pkg::BASE_RED;
      out_green_r <= rss_pkg::BASE_GREEN;
      out_blue_r  <= rss_pkg::BASE_BLUE;
    end else begin
      out_red_r   <= red_c;
      out_green_r <= 8'd0;
      out_blue_r  <= blue_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
    end else begin
      out_valid_r <= vq_c;
      out_hit_r   <= vq_c && !payq_c[1];
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

// ===== rtl/rss_checker.sv =====
`include "ray_sphere_pixel_shader_defines.svh"

// Port-level checks on the shaded results.
module rss_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_hit
);

  // A miss is black
  `RSS_ASSERT_IMP(a_miss_black, out_valid && !out_hit, out_red == 8'd0 && out_blue == 8'd0)
  // Green base is zero, so green never lights
  `RSS_ASSERT_IMP(a_green_dark, out_valid, out_green == 8'd0)
  // Hit flag only with a result transfer
  `RSS_ASSERT_NEVER(a_hit_strobe, out_hit && !out_valid)
  // Blue base exceeds red base under the same shading factor
  `RSS_ASSERT_IMP(a_blue_ge_red, out_hit, out_blue >= out_red)

endmodule

bind ray_sphere_pixel_shader rss_checker u_rss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_red   (out_red),
  .out_green (out_green),
  .out_blue  (out_blue),
  .out_hit   (out_hit)
);

// ===== tb/sv/ray_sphere_pixel_shader_test.sv =====
`timescale 1ns / 1ps

module ray_sphere_pixel_shader_test;

  localparam int  IMG_W        = 256;
  localparam int  IMG_H        = 256;
  localparam int  PIPE_LATENCY = 126;
  localparam int  CYCLE_LIMIT  = 400000;
  localparam int  RANDOM_ITEMS = 600;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       hit;
  } pixel_color_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [7:0]  in_pixel_col;
  logic [7:0]  in_pixel_row;
  logic        out_valid;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_hit;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  logic [15:0]  scene_regs [7];
  pixel_color_t pending_colors [$];
  int           errors;
  int           pixels_sent;
  int           colors_seen;
  int           hits_seen;
  int           reg_writes;
  int           cycles;
  bit           burst_mode;

  ray_sphere_pixel_shader #(
    .IMAGE_WIDTH (IMG_W),
    .IMAGE_HEIGHT(IMG_H)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_pixel_col(in_pixel_col),
    .in_pixel_row(in_pixel_row),
    .out_valid   (out_valid),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_hit     (out_hit),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Guard against a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint trunc_shift(longint v, int n);
    if (v < 0) return -((-v) >>> n);
    return v >>> n;
  endfunction

  function automatic logic [7:0] lambert_channel(longint base, longint dot, longint den);
    longint v;
    if (den == 0) v = base;
    else v = (base * (den + dot)) / den;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // Trace the eye ray for one pixel and shade the nearest hit
  function automatic pixel_color_t shade_pixel(logic [7:0] col, logic [7:0] row);
    pixel_color_t c;
    longint ex, ey, ez, n, ux, uy, uz;
    longint sx, sy, sz, r, lx, ly, lz;
    longint l2, r2, h, disc, t, px, py, pz;
    longint nx, ny, nz, vx, vy, vz, dot, den;
    c  = '0;
    ex = (longint'(IMG_W) - 1 - 2 * longint'(col)) * 10 * IMG_H;
    ey = (longint'(IMG_H) - 1 - 2 * longint'(row)) * 10 * IMG_W;
    ez = longint'(14) * IMG_W * IMG_H;
    n  = longint'(int_sqrt(ex * ex + ey * ey + ez * ez));
    if (n == 0) return c;
    ux = (ex * (longint'(1) << rss_pkg::UNIT_SHIFT)) / n;
    uy = (ey * (longint'(1) << rss_pkg::UNIT_SHIFT)) / n;
    uz = (ez * (longint'(1) << rss_pkg::UNIT_SHIFT)) / n;
    sx = longint'($signed(scene_regs[rss_pkg::REG_SPHERE_X]));
    sy = longint'($signed(scene_regs[rss_pkg::REG_SPHERE_Y]));
    sz = longint'($signed(scene_regs[rss_pkg::REG_SPHERE_Z]));
    r  = longint'(scene_regs[rss_pkg::REG_SPHERE_R][14:0]);
    lx = longint'($signed(scene_regs[rss_pkg::REG_LIGHT_X]));
    ly = longint'($signed(scene_regs[rss_pkg::REG_LIGHT_Y]));
    lz = longint'($signed(scene_regs[rss_pkg::REG_LIGHT_Z]));
    l2 = sx * sx + sy * sy + sz * sz;
    r2 = r * r;
    if (l2 <= r2) return c;
    h = ux * sx + uy * sy + uz * sz;
    disc = h * h - (l2 - r2) * (longint'(1) << rss_pkg::C_SHIFT);
    if (disc < 0 || h <= 0) return c;
    t  = h - longint'(int_sqrt(disc));
    px = trunc_shift(t * ux, rss_pkg::PT_SHIFT);
    py = trunc_shift(t * uy, rss_pkg::PT_SHIFT);
    pz = trunc_shift(t * uz, rss_pkg::PT_SHIFT);
    nx = px - sx * 256; ny = py - sy * 256; nz = pz - sz * 256;
    vx = lx * 256 - px; vy = ly * 256 - py; vz = lz * 256 - pz;
    dot = nx * vx + ny * vy + nz * vz;
    den = longint'(int_sqrt(nx * nx + ny * ny + nz * nz) *
                   int_sqrt(vx * vx + vy * vy + vz * vz));
    c.red   = lambert_channel(rss_pkg::BASE_RED, dot, den);
    c.green = lambert_channel(rss_pkg::BASE_GREEN, dot, den);
    c.blue  = lambert_channel(rss_pkg::BASE_BLUE, dot, den);
    c.hit   = 1'b1;
    return c;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("mismatch on color %0d: %s got %0d expected %0d", colors_seen, what, got, want);
  endtask

  // Compare each strobed color against the oldest prediction
  always @(posedge clk) begin
    pixel_color_t want;
    if (rst_n && out_valid) begin
      if (pending_colors.size() == 0) begin
        report_mismatch("unexpected strobe", 1, 0);
      end else begin
        want = pending_colors.pop_front();
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
        if (want.hit) hits_seen++;
      end
      colors_seen++;
    end
  end

  // Drive one pixel, wait for the transfer, then, unless in burst mode, hold off for a random gap
  task automatic send_pixel(logic [7:0] col, logic [7:0] row);
    bit took;
    int gap;
    start        <= 1'b1;
    in_pixel_col <= col;
    in_pixel_row <= row;
    do begin
      @(negedge clk);
      took = !busy;
      @(posedge clk);
    end while (!took);
    pending_colors.push_back(shade_pixel(col, row));
    pixels_sent++;
    gap = burst_mode ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and let every pixel in flight come out
  task automatic drain_pipe();
    start <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    bit took;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    if (idx == rss_pkg::REG_SPHERE_R) scene_regs[idx] = {1'b0, value[14:0]};
    else if (idx != REG_UNUSED) scene_regs[idx] = value;
    reg_writes++;
    @(posedge clk);
  endtask

  task automatic load_scene(int sx, int sy, int sz, int r, int lx, int ly, int lz);
    drain_pipe();
    write_reg(rss_pkg::REG_SPHERE_X, 16'(sx));
    write_reg(rss_pkg::REG_SPHERE_Y, 16'(sy));
    write_reg(rss_pkg::REG_SPHERE_Z, 16'(sz));
    write_reg(rss_pkg::REG_SPHERE_R, 16'(r));
    write_reg(rss_pkg::REG_LIGHT_X, 16'(lx));
    write_reg(rss_pkg::REG_LIGHT_Y, 16'(ly));
    write_reg(rss_pkg::REG_LIGHT_Z, 16'(lz));
  endtask

  // Corners, center and two off-center points of the image with the reset scene
  task automatic test_reset_scene();
    burst_mode = 1'b0;
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd127, 8'd128);
    send_pixel(8'd128, 8'd127);
    send_pixel(8'd170, 8'd85);
    send_pixel(8'd85, 8'd170);
  endtask

  // Miss cases, clamping and out-of-range register writes
  task automatic test_special_cases();
    // eye inside the sphere
    load_scene(0, 0, 256, 1024, 0, 2560, 0);
    send_pixel(8'd128, 8'd128);
    // sphere far off axis: negative discriminant
    load_scene(20000, 20000, 2560, 256, 0, 2560, 0);
    send_pixel(8'd128, 8'd128);
    // sphere behind the eye
    load_scene(0, 0, -2560, 1024, 0, 2560, 0);
    send_pixel(8'd128, 8'd128);
    // light inside the sphere gives a negative cosine
    load_scene(0, 0, 2560, 1024, 0, 0, 2560);
    send_pixel(8'd128, 8'd128);
    send_pixel(8'd100, 8'd140);
    // zero radius and extreme register values
    load_scene(0, 0, 2560, 0, 32767, -32768, 32767);
    send_pixel(8'd127, 8'd127);
    load_scene(-32768, -32768, 32767, 32767, -32768, 32767, -32768);
    send_pixel(8'd0, 8'd0);
    load_scene(0, 0, 32767, 32767, 0, 0, -32768);
    send_pixel(8'd128, 8'd128);
    send_pixel(8'd255, 8'd0);
    // write to a register index past the last one is dropped
    drain_pipe();
    write_reg(REG_UNUSED, 16'hFFFF);
    send_pixel(8'd64, 8'd192);
  endtask

  // Random pixels across a series of random scenes
  task automatic test_random_scenes();
    for (int scene = 0; scene < 12; scene++) begin
      if (scene % 4 == 3)
        load_scene($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 32767),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
      else
        load_scene($urandom_range(0, 2048) - 1024, $urandom_range(0, 2048) - 1024,
                   $urandom_range(512, 8192), $urandom_range(64, 3000),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535));
      for (int i = 0; i < RANDOM_ITEMS / 12; i++) begin
        if (i % 10 == 0) burst_mode = ($urandom_range(0, 2) == 0);
        send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end
    end
    burst_mode = 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_pixel_col = '0;
    in_pixel_row = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    errors       = 0;
    pixels_sent  = 0;
    colors_seen  = 0;
    hits_seen    = 0;
    reg_writes   = 0;
    cycles       = 0;
    burst_mode   = 1'b0;
    scene_regs[rss_pkg::REG_SPHERE_X] = 16'd0;
    scene_regs[rss_pkg::REG_SPHERE_Y] = 16'd0;
    scene_regs[rss_pkg::REG_SPHERE_Z] = 16'd2560;
    scene_regs[rss_pkg::REG_SPHERE_R] = 16'd1024;
    scene_regs[rss_pkg::REG_LIGHT_X]  = 16'd0;
    scene_regs[rss_pkg::REG_LIGHT_Y]  = 16'd2560;
    scene_regs[rss_pkg::REG_LIGHT_Z]  = 16'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_scene();
    test_special_cases();
    test_random_scenes();

    start <= 1'b0;
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 10) @(posedge clk);
    if (pending_colors.size() != 0) report_mismatch("missing colors", 0, 1);

    $display("shaded %0d pixels (%0d hits) over %0d register writes",
             pixels_sent, hits_seen, reg_writes);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
